// File: rtl/crcfc_pkg.sv
package crcfc_pkg;

  localparam logic [15:0] CRC_INIT           = 16'hFFFF;
  localparam logic [15:0] CRC_XOROUT         = 16'hFFFF;
  // 0x8005 bit-reversed for the LSB-first register
  localparam logic [15:0] CRC_POLY_REFLECTED = 16'hA001;
  localparam logic [7:0]  RESET_LENGTH       = 8'd36;
  localparam logic [7:0]  POS_MAX            = 8'd255;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_LEN_ERR    = 2'd1,
    STATUS_CRC_ERR    = 2'd2,
    STATUS_SHORT      = 2'd3
  } status_t;

endpackage

// File: rtl/crc16_frame_checker_unit.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+------------------------------------------------
// input    | in_valid / in_ready   | rx_byte[7:0], frame_end
// result   | out_valid / out_ready | status[1:0], computed_crc[15:0],
//          |                       | received_crc[15:0], frame_length[7:0]
// config   | cfg_valid / cfg_ready | cfg_data[7:0] (expected length)
//
// One byte per cycle unless a frame-end byte waits on a verdict: a byte is held in
// the input register, and the CRC update and frame bookkeeping retire it from there.
// A frame-end byte writes the verdict into the result register; a verdict
// still waiting there holds the next frame-end byte in the input register.
// Non-end bytes keep flowing while a verdict waits. cfg_ready is always high.
// Synchronous reset: expected length 36, frame state cleared, no beats held.
module crc16_frame_checker_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] computed_crc,
  output logic [15:0] received_crc,
  output logic [7:0]  frame_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import crcfc_pkg::*;

  logic [7:0]  expected_length;

  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic        hold_end;

  logic [7:0]  byte_position;
  logic [15:0] crc_accumulator;
  logic [15:0] captured_crc;
  logic [7:0]  seen_length;

  logic        advance;
  logic        active;
  logic [7:0]  len_cur;
  logic [8:0]  len_plus1;
  logic [8:0]  len_plus2;
  logic [15:0] crc_upd;
  logic [15:0] crc_next;
  logic [15:0] captured_next;
  logic [7:0]  pos_next;
  logic [15:0] crc_final;
  status_t     status_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= RESET_LENGTH;
    end else if (cfg_valid) begin
      expected_length <= cfg_data;
    end
  end

  // Retire the held beat unless it carries a verdict that has nowhere to go
  assign advance  = hold_valid && (!hold_end || !out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_byte <= rx_byte;
      hold_end  <= frame_end;
    end
  end

  crcfc_crc_byte u_crc (
    .crc_in  (crc_accumulator),
    .data    (hold_byte),
    .crc_out (crc_upd)
  );

  always_comb begin
    active        = byte_position != POS_MAX;
    len_cur       = (byte_position == 8'd0) ? hold_byte : seen_length;
    len_plus1     = {1'b0, len_cur} + 9'd1;
    crc_next      = crc_accumulator;
    captured_next = captured_crc;
    pos_next      = byte_position;
    if (active) begin
      if (byte_position < len_cur) begin
        crc_next = crc_upd;
      end
      if (byte_position == len_cur) begin
        captured_next[7:0] = hold_byte;
      end
      if ({1'b0, byte_position} == len_plus1) begin
        captured_next[15:8] = hold_byte;
      end
      pos_next = byte_position + 8'd1;
    end
    len_plus2 = {1'b0, len_cur} + 9'd2;
    crc_final = crc_next ^ CRC_XOROUT;
    priority if (len_cur != expected_length) begin
      status_next = STATUS_LEN_ERR;
    end else if ({1'b0, pos_next} < len_plus2) begin
      status_next = STATUS_SHORT;
    end else if (crc_final == captured_next) begin
      status_next = STATUS_OK;
    end else begin
      status_next = STATUS_CRC_ERR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= 8'd0;
      crc_accumulator <= CRC_INIT;
      captured_crc    <= 16'd0;
      seen_length     <= 8'd0;
    end else if (advance) begin
      if (hold_end) begin
        byte_position   <= 8'd0;
        crc_accumulator <= CRC_INIT;
        captured_crc    <= 16'd0;
        seen_length     <= 8'd0;
      end else begin
        byte_position   <= pos_next;
        crc_accumulator <= crc_next;
        captured_crc    <= captured_next;
        if (active) begin
          seen_length <= len_cur;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && hold_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold_end) begin
      status       <= status_next;
      frame_length <= active ? len_cur : seen_length;
      if (status_next == STATUS_OK || status_next == STATUS_CRC_ERR) begin
        computed_crc <= crc_final;
        received_crc <= captured_next;
      end else begin
        computed_crc <= 16'd0;
        received_crc <= 16'd0;
      end
    end
  end

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    advance && hold_end |=> byte_position == 8'd0 && crc_accumulator == CRC_INIT)
    else $error("frame state not cleared after frame end");

  a_ok_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_OK |-> computed_crc == received_crc)
    else $error("ok verdict with differing CRCs");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_LEN_ERR || status == STATUS_SHORT)
      |-> computed_crc == 16'd0 && received_crc == 16'd0)
    else $error("CRC fields not zero on length or short verdict");

  a_saturate: assert property (@(posedge clk) disable iff (rst)
    advance && !hold_end && byte_position == POS_MAX |=> byte_position == POS_MAX)
    else $error("byte position left saturation");

  a_verdict_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(computed_crc))
    else $error("pending verdict overwritten");

endmodule

// File: rtl/crcfc_crc_byte.sv
module crcfc_crc_byte (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);
  import crcfc_pkg::*;

  // Eight unrolled shift-and-reduce steps, LSB first
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFLECTED;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import crcfc_pkg::*;

  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_GAP        = 20;

  typedef struct packed {
    status_t     status;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
    logic [7:0]  frame_length;
  } verdict_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        frame_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [15:0] computed_crc;
  logic [15:0] received_crc;
  logic [7:0]  frame_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'h00;

  // shadow of the checker state
  logic [7:0]  want_length = RESET_LENGTH;
  logic [7:0]  byte_pos    = 8'd0;
  logic [15:0] crc_reg     = CRC_INIT;
  logic [15:0] crc_seen    = 16'h0000;
  logic [7:0]  len_seen    = 8'd0;

  verdict_t    pending_verdicts[$];
  verdict_t    want;
  logic [7:0]  frame_bytes[$];
  bit          failed = 1'b0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          beats_sent = 0;
  int          quiet_cycles = 0;

  crc16_frame_checker_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .frame_end    (frame_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .computed_crc (computed_crc),
    .received_crc (received_crc),
    .frame_length (frame_length),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] crc16_usb_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY_REFLECTED) : (c >> 1);
    return c;
  endfunction

  task automatic track_byte(input logic [7:0] b, input logic e);
    verdict_t v;
    if (byte_pos != POS_MAX) begin
      if (byte_pos == 8'd0) len_seen = b;
      if (byte_pos < len_seen) crc_reg = crc16_usb_step(crc_reg, b);
      if (byte_pos == len_seen) crc_seen[7:0] = b;
      if ({1'b0, byte_pos} == {1'b0, len_seen} + 9'd1) crc_seen[15:8] = b;
      byte_pos = byte_pos + 8'd1;
    end
    if (e) begin
      v.computed_crc = 16'h0000;
      v.received_crc = 16'h0000;
      v.frame_length = len_seen;
      if (len_seen != want_length) begin
        v.status = STATUS_LEN_ERR;
      end else if ({1'b0, byte_pos} < {1'b0, len_seen} + 9'd2) begin
        v.status = STATUS_SHORT;
      end else begin
        v.computed_crc = crc_reg ^ CRC_XOROUT;
        v.received_crc = crc_seen;
        v.status = (v.computed_crc == v.received_crc) ? STATUS_OK : STATUS_CRC_ERR;
      end
      pending_verdicts.push_back(v);
      byte_pos = 8'd0;
      crc_reg  = CRC_INIT;
      crc_seen = 16'h0000;
      len_seen = 8'd0;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic e);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    rx_byte   <= b;
    frame_end <= e;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    track_byte(b, e);
  endtask

  // noisy: frame_end may also fall inside the sequence
  task automatic send_frame(input bit noisy);
    int last;
    last = frame_bytes.size() - 1;
    for (int i = 0; i <= last; i++)
      send_byte(frame_bytes[i], (i == last) || (noisy && $urandom_range(3) == 0));
  endtask

  task automatic build_good(input int len);
    logic [15:0] c;
    frame_bytes = {};
    frame_bytes.push_back(len[7:0]);
    for (int i = 1; i < len; i++) frame_bytes.push_back(8'($urandom_range(255)));
    c = CRC_INIT;
    for (int i = 0; i < len; i++) c = crc16_usb_step(c, frame_bytes[i]);
    c = c ^ CRC_XOROUT;
    // zero length: byte 0 doubles as the low CRC byte
    if (len != 0) frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(c[15:8]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    want_length = v;
  endtask

  task automatic test_reset_length();
    build_good(int'(RESET_LENGTH));
    send_frame(1'b0);
    drain();
  endtask

  task automatic test_min_length();
    write_length(8'd1);
    build_good(1);
    send_frame(1'b0);
    build_good(1);
    frame_bytes[2] ^= 8'h80;
    send_frame(1'b0);
    frame_bytes = {8'd1};
    send_frame(1'b0);
    build_good(1);
    frame_bytes.push_back(8'hFF);
    frame_bytes.push_back(8'h00);
    send_frame(1'b0);
    frame_bytes = {8'hFF, 8'h00};
    send_frame(1'b0);
    frame_bytes = {8'h00};
    send_frame(1'b0);
    drain();
  endtask

  task automatic test_zero_length();
    write_length(8'd0);
    build_good(0);
    send_frame(1'b0);
    frame_bytes = {8'h00};
    send_frame(1'b0);
    frame_bytes = {8'h00, 8'hFF};
    send_frame(1'b0);
    drain();
  endtask

  task automatic test_unreachable_length();
    write_length(8'd255);
    frame_bytes = {8'd255};
    send_frame(1'b0);
    drain();
    write_length(8'd254);
    frame_bytes = {8'd254, 8'h00};
    send_frame(1'b0);
    drain();
  endtask

  // position counter saturates; trailing bytes past 255 are dropped
  task automatic test_long_frames();
    write_length(8'd253);
    build_good(253);
    repeat (3) frame_bytes.push_back(8'($urandom_range(255)));
    send_frame(1'b0);
    drain();
    write_length(8'd254);
    frame_bytes = {8'd254};
    repeat (259) frame_bytes.push_back(8'($urandom_range(255)));
    send_frame(1'b0);
    drain();
  endtask

  task automatic test_random_frames(input int idle, input int stall, input int n_items);
    int start;
    int frames;
    int kind;
    int len;
    int cut;
    int pick;
    idle_pct  = idle;
    stall_pct = stall;
    start     = beats_sent;
    frames    = 0;
    while (beats_sent - start < n_items) begin
      if (frames % 6 == 0) begin
        drain();
        pick = $urandom_range(99);
        if (pick < 8) write_length(8'd0);
        else if (pick < 16) write_length(8'd1);
        else write_length(8'($urandom_range(2, 40)));
      end
      kind = $urandom_range(99);
      if (kind < 55) begin
        build_good(int'(want_length));
        if ($urandom_range(4) == 0)
          repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom_range(255)));
        send_frame(1'b0);
      end else if (kind < 70) begin
        build_good(int'(want_length));
        cut = $urandom_range(frame_bytes.size() - 1);
        frame_bytes[cut] ^= 8'h01 << $urandom_range(7);
        send_frame(1'b0);
      end else if (kind < 80) begin
        build_good(int'(want_length));
        cut = $urandom_range(1, frame_bytes.size() - 1);
        while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
        send_frame(1'b0);
      end else if (kind < 90) begin
        do len = $urandom_range(255); while (len == want_length);
        frame_bytes = {len[7:0]};
        repeat ($urandom_range(0, 12)) frame_bytes.push_back(8'($urandom_range(255)));
        send_frame(1'b0);
      end else begin
        frame_bytes = {};
        repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(255)));
        send_frame(1'b1);
      end
      frames++;
    end
    drain();
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected verdict: status %0d frame_length %0d", status, frame_length);
        failed = 1'b1;
      end else begin
        want = pending_verdicts.pop_front();
        if (want.status !== status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          failed = 1'b1;
        end
        if (want.computed_crc !== computed_crc) begin
          $error("computed_crc: expected %h, actual %h", want.computed_crc, computed_crc);
          failed = 1'b1;
        end
        if (want.received_crc !== received_crc) begin
          $error("received_crc: expected %h, actual %h", want.received_crc, received_crc);
          failed = 1'b1;
        end
        if (want.frame_length !== frame_length) begin
          $error("frame_length: expected %0d, actual %0d", want.frame_length, frame_length);
          failed = 1'b1;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_length();
    test_min_length();
    test_zero_length();
    test_unreachable_length();
    test_long_frames();
    test_random_frames(0, 0, 300);
    test_random_frames(55, 0, 300);
    test_random_frames(0, 55, 300);
    test_random_frames(30, 30, 300);
    drain();
    if (!failed && pending_verdicts.size() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
